// ----- rtl/core/qrs_pkg.sv -----
// Shared constants and types for the quadratic root solver.
`timescale 1ns / 1ps
`default_nettype none
package qrs_pkg;

  localparam int COEF_WIDTH_DEF = 16;
  localparam int FRAC_BITS_DEF  = 16;
  localparam int ROOT_WIDTH     = 37;
  localparam int QUEUE_DEPTH    = 4;

  typedef enum logic [2:0] {
    CASE_TWO    = 3'd0,
    CASE_ONE    = 3'd1,
    CASE_NONE   = 3'd2,
    CASE_LINEAR = 3'd3,
    CASE_DEGEN  = 3'd4
  } case_code_t;

  // Classification made in the front end.
  typedef struct packed {
    logic a_zero;
    logic b_zero;
    logic ac_pos;
  } qrs_cls_t;

endpackage
`default_nettype wire

// ----- rtl/core/qrs_front.sv -----
// Front end: accept a coefficient beat, form the products and classify.
`timescale 1ns / 1ps
`default_nettype none
module qrs_front #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF
) (
  input  wire                           clk,
  input  wire                           rst_n,
  input  wire                           in_valid,
  output logic                          in_stall,
  input  wire  signed [COEF_WIDTH-1:0]  in_coef_a,
  input  wire  signed [COEF_WIDTH-1:0]  in_coef_b,
  input  wire  signed [COEF_WIDTH-1:0]  in_coef_c,
  input  wire                           q_full,
  output logic                          fr_valid,
  output logic signed [COEF_WIDTH-1:0]  fr_a,
  output logic signed [COEF_WIDTH-1:0]  fr_b,
  output logic signed [COEF_WIDTH-1:0]  fr_c,
  output logic [2*COEF_WIDTH-1:0]       fr_bb,
  output logic [2*COEF_WIDTH-1:0]       fr_ac,
  output qrs_pkg::qrs_cls_t             fr_cls
);

  localparam int CW = COEF_WIDTH;

  logic                 valid_r, valid_nxt;
  logic                 take;
  logic [CW-1:0]        a_mag, b_mag, c_mag;
  qrs_pkg::qrs_cls_t    cls;

  assign in_stall = valid_r && q_full;
  assign take     = in_valid && !in_stall;

  always_comb begin
    a_mag = in_coef_a[CW-1] ? (~in_coef_a + 1'b1) : in_coef_a;
    b_mag = in_coef_b[CW-1] ? (~in_coef_b + 1'b1) : in_coef_b;
    c_mag = in_coef_c[CW-1] ? (~in_coef_c + 1'b1) : in_coef_c;
    cls.a_zero = (in_coef_a == '0);
    cls.b_zero = (in_coef_b == '0);
    cls.ac_pos = (in_coef_a != '0) && (in_coef_c != '0) &&
                 (in_coef_a[CW-1] == in_coef_c[CW-1]);
  end

  always_comb begin
    valid_nxt = valid_r;
    if (take) begin
      valid_nxt = 1'b1;
    end else if (valid_r && !q_full) begin
      valid_nxt = 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else begin
      valid_r <= valid_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (take) begin
      fr_a   <= in_coef_a;
      fr_b   <= in_coef_b;
      fr_c   <= in_coef_c;
      fr_bb  <= b_mag * b_mag;
      fr_ac  <= a_mag * c_mag;
      fr_cls <= cls;
    end
  end

  assign fr_valid = valid_r;

endmodule
`default_nettype wire

// ----- rtl/core/qrs_fifo.sv -----
// Short queue between front and back end.
`timescale 1ns / 1ps
`default_nettype none
module qrs_fifo #(
  parameter int WIDTH = 8
) (
  input  wire              clk,
  input  wire              rst_n,
  input  wire              push,
  input  wire [WIDTH-1:0]  din,
  output logic             full,
  input  wire              pop,
  output logic             empty,
  output logic [WIDTH-1:0] dout
);

  localparam int DEPTH = qrs_pkg::QUEUE_DEPTH;
  localparam int PW    = $clog2(DEPTH);
  localparam int CNTW  = $clog2(DEPTH + 1);

  logic [WIDTH-1:0] mem [0:DEPTH-1];
  logic [PW-1:0]    wr_ptr_r, rd_ptr_r;
  logic [CNTW-1:0]  cnt_r, cnt_nxt;
  logic             do_push, do_pop;

  assign full    = (cnt_r == CNTW'(DEPTH));
  assign empty   = (cnt_r == '0);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign dout    = mem[rd_ptr_r];

  always_comb begin
    cnt_nxt = cnt_r;
    if (do_push && !do_pop) begin
      cnt_nxt = cnt_r + 1'b1;
    end else if (do_pop && !do_push) begin
      cnt_nxt = cnt_r - 1'b1;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      cnt_r <= cnt_nxt;
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr_r] <= din;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/qrs_div.sv -----
// Pipelined restoring divider, one quotient bit per stage.
`timescale 1ns / 1ps
`default_nettype none
module qrs_div #(
  parameter int NUM_WIDTH = 8,
  parameter int DEN_WIDTH = 8
) (
  input  wire                  clk,
  input  wire                  en,
  input  wire [NUM_WIDTH-1:0]  num_i,
  input  wire [DEN_WIDTH-1:0]  den_i,
  output logic [NUM_WIDTH-1:0] quo_o
);

  localparam int RMW = DEN_WIDTH + 1;

  logic [NUM_WIDTH-1:0] num_r [0:NUM_WIDTH-1];
  logic [NUM_WIDTH-1:0] quo_r [0:NUM_WIDTH-1];
  logic [DEN_WIDTH-1:0] den_r [0:NUM_WIDTH-1];
  logic [RMW-1:0]       rem_r [0:NUM_WIDTH-1];

  for (genvar i = 0; i < NUM_WIDTH; i++) begin : g_stage
    logic [NUM_WIDTH-1:0] num_in, quo_in;
    logic [DEN_WIDTH-1:0] den_in;
    logic [RMW-1:0]       rem_in, rem_sh;
    logic                 ge;

    if (i == 0) begin : g_first
      assign num_in = num_i;
      assign quo_in = '0;
      assign den_in = den_i;
      assign rem_in = '0;
    end else begin : g_next
      assign num_in = num_r[i-1];
      assign quo_in = quo_r[i-1];
      assign den_in = den_r[i-1];
      assign rem_in = rem_r[i-1];
    end

    assign rem_sh = {rem_in[RMW-2:0], num_in[NUM_WIDTH-1]};
    assign ge     = rem_sh >= {1'b0, den_in};

    always_ff @(posedge clk) begin
      if (en) begin
        num_r[i] <= num_in << 1;
        den_r[i] <= den_in;
        rem_r[i] <= ge ? (rem_sh - {1'b0, den_in}) : rem_sh;
        quo_r[i] <= {quo_in[NUM_WIDTH-2:0], ge};
      end
    end
  end

  assign quo_o = quo_r[NUM_WIDTH-1];

endmodule
`default_nettype wire

// ----- rtl/core/qrs_back.sv -----
// Back end: discriminant, pipelined square root, two pipelined divisions.
`timescale 1ns / 1ps
`default_nettype none
module qrs_back #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire                                 clk,
  input  wire                                 rst_n,
  input  wire                                 q_empty,
  output logic                                q_pop,
  input  wire  signed [COEF_WIDTH-1:0]        q_a,
  input  wire  signed [COEF_WIDTH-1:0]        q_b,
  input  wire  signed [COEF_WIDTH-1:0]        q_c,
  input  wire  [2*COEF_WIDTH-1:0]             q_bb,
  input  wire  [2*COEF_WIDTH-1:0]             q_ac,
  input  qrs_pkg::qrs_cls_t                   q_cls,
  output logic                                out_valid,
  input  wire                                 out_stall,
  output logic [2:0]                          out_case_code,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_plus,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_minus
);

  localparam int CW   = COEF_WIDTH;
  localparam int BW   = 2 * CW;
  localparam int DW   = 2 * CW + 1;
  localparam int RAD  = DW + 2 * FRAC_BITS;
  localparam int RW   = (RAD + 1) / 2;
  localparam int RADP = 2 * RW;
  localparam int REMW = RW + 3;
  localparam int NB   = CW + FRAC_BITS + 1;
  localparam int NS   = ((NB > RW + 1) ? NB : RW + 1) + 1;
  localparam int DNW  = CW + 1;
  localparam int RTW  = qrs_pkg::ROOT_WIDTH;
  localparam int SW   = (NS + 1 > RTW) ? NS + 1 : RTW;
  localparam int L    = RW + NS + 2;

  logic adv;
  logic [L-1:0] vld_r;
  logic         out_valid_r;

  assign adv   = !out_valid_r || !out_stall;
  assign q_pop = adv && !q_empty;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      vld_r       <= '0;
      out_valid_r <= 1'b0;
    end else if (adv) begin
      vld_r       <= {vld_r[L-2:0], q_pop};
      out_valid_r <= vld_r[L-1];
    end
  end

  assign out_valid = out_valid_r;

  // Stage 0: discriminant and case code.
  logic [DW-1:0]            bb_w, ac4, d_sum, d_dif, d_val;
  logic [CW-1:0]            a_mag, b_mag;
  qrs_pkg::case_code_t      code0;
  logic signed [NS-1:0]     b_ext, c_ext;
  logic [RADP-1:0]          s0_rad_r;
  qrs_pkg::case_code_t      s0_code_r;
  logic signed [NS-1:0]     s0_num_r;
  logic [DNW-1:0]           s0_den_r;
  logic                     s0_dneg_r;

  always_comb begin
    bb_w  = {1'b0, q_bb};
    ac4   = {q_ac[BW-2:0], 2'b00};
    d_sum = bb_w + ac4;
    d_dif = bb_w - ac4;
    a_mag = q_a[CW-1] ? (~q_a + 1'b1) : q_a;
    b_mag = q_b[CW-1] ? (~q_b + 1'b1) : q_b;
    b_ext = $signed({{(NS-CW){q_b[CW-1]}}, q_b});
    c_ext = $signed({{(NS-CW){q_c[CW-1]}}, q_c});
    d_val = '0;
    if (q_cls.a_zero) begin
      code0 = q_cls.b_zero ? qrs_pkg::CASE_DEGEN : qrs_pkg::CASE_LINEAR;
    end else if (!q_cls.ac_pos) begin
      d_val = d_sum;
      code0 = (d_sum != '0) ? qrs_pkg::CASE_TWO : qrs_pkg::CASE_ONE;
    end else if (bb_w > ac4) begin
      d_val = d_dif;
      code0 = qrs_pkg::CASE_TWO;
    end else if (bb_w == ac4) begin
      code0 = qrs_pkg::CASE_ONE;
    end else begin
      code0 = qrs_pkg::CASE_NONE;
    end
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      s0_code_r <= code0;
      s0_rad_r  <= RADP'(d_val) << (2 * FRAC_BITS);
      s0_num_r  <= q_cls.a_zero ? -(c_ext <<< FRAC_BITS) : -(b_ext <<< FRAC_BITS);
      s0_den_r  <= q_cls.a_zero ? {1'b0, b_mag} : {a_mag, 1'b0};
      s0_dneg_r <= q_cls.a_zero ? q_b[CW-1] : q_a[CW-1];
    end
  end

  // Square root: two radicand bits per stage.
  logic [RW-1:0]        sq_root_r [0:RW-1];
  logic [REMW-1:0]      sq_rem_r  [0:RW-1];
  logic [RADP-1:0]      sq_rad_r  [0:RW-1];
  qrs_pkg::case_code_t  sq_code_r [0:RW-1];
  logic signed [NS-1:0] sq_num_r  [0:RW-1];
  logic [DNW-1:0]       sq_den_r  [0:RW-1];
  logic                 sq_dneg_r [0:RW-1];

  for (genvar i = 0; i < RW; i++) begin : g_sqrt
    logic [RW-1:0]        root_in;
    logic [REMW-1:0]      rem_in, rem_sh, trial;
    logic [RADP-1:0]      rad_in;
    qrs_pkg::case_code_t  code_in;
    logic signed [NS-1:0] num_in;
    logic [DNW-1:0]       den_in;
    logic                 dneg_in;
    logic                 ge;

    if (i == 0) begin : g_first
      assign root_in = '0;
      assign rem_in  = '0;
      assign rad_in  = s0_rad_r;
      assign code_in = s0_code_r;
      assign num_in  = s0_num_r;
      assign den_in  = s0_den_r;
      assign dneg_in = s0_dneg_r;
    end else begin : g_next
      assign root_in = sq_root_r[i-1];
      assign rem_in  = sq_rem_r[i-1];
      assign rad_in  = sq_rad_r[i-1];
      assign code_in = sq_code_r[i-1];
      assign num_in  = sq_num_r[i-1];
      assign den_in  = sq_den_r[i-1];
      assign dneg_in = sq_dneg_r[i-1];
    end

    assign rem_sh = {rem_in[REMW-3:0], rad_in[RADP-1:RADP-2]};
    assign trial  = {1'b0, root_in, 2'b01};
    assign ge     = rem_sh >= trial;

    always_ff @(posedge clk) begin
      if (adv) begin
        sq_root_r[i] <= {root_in[RW-2:0], ge};
        sq_rem_r[i]  <= ge ? (rem_sh - trial) : rem_sh;
        sq_rad_r[i]  <= rad_in << 2;
        sq_code_r[i] <= code_in;
        sq_num_r[i]  <= num_in;
        sq_den_r[i]  <= den_in;
        sq_dneg_r[i] <= dneg_in;
      end
    end
  end

  // Numerators, then split into magnitude and quotient sign.
  logic signed [NS-1:0] s_ext, np, nm;
  logic [NS-1:0]        nm_p_r, nm_m_r;
  logic                 neg_p_r, neg_m_r;
  logic [DNW-1:0]       nd_den_r;
  qrs_pkg::case_code_t  nd_code_r;

  always_comb begin
    s_ext = $signed({{(NS-RW){1'b0}}, sq_root_r[RW-1]});
    case (sq_code_r[RW-1])
      qrs_pkg::CASE_TWO: begin
        np = sq_num_r[RW-1] + s_ext;
        nm = sq_num_r[RW-1] - s_ext;
      end
      qrs_pkg::CASE_ONE, qrs_pkg::CASE_LINEAR: begin
        np = sq_num_r[RW-1];
        nm = sq_num_r[RW-1];
      end
      default: begin
        np = '0;
        nm = '0;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      nm_p_r    <= np[NS-1] ? NS'(-np) : NS'(np);
      nm_m_r    <= nm[NS-1] ? NS'(-nm) : NS'(nm);
      neg_p_r   <= np[NS-1] ^ sq_dneg_r[RW-1];
      neg_m_r   <= nm[NS-1] ^ sq_dneg_r[RW-1];
      nd_den_r  <= sq_den_r[RW-1];
      nd_code_r <= sq_code_r[RW-1];
    end
  end

  logic [NS-1:0] quo_p, quo_m;

  qrs_div #(.NUM_WIDTH(NS), .DEN_WIDTH(DNW)) u_div_p (
    .clk   (clk),
    .en    (adv),
    .num_i (nm_p_r),
    .den_i (nd_den_r),
    .quo_o (quo_p)
  );

  qrs_div #(.NUM_WIDTH(NS), .DEN_WIDTH(DNW)) u_div_m (
    .clk   (clk),
    .en    (adv),
    .num_i (nm_m_r),
    .den_i (nd_den_r),
    .quo_o (quo_m)
  );

  qrs_pkg::case_code_t dv_code_r  [0:NS-1];
  logic                dv_neg_p_r [0:NS-1];
  logic                dv_neg_m_r [0:NS-1];

  for (genvar i = 0; i < NS; i++) begin : g_side
    always_ff @(posedge clk) begin
      if (adv) begin
        if (i == 0) begin
          dv_code_r[i]  <= nd_code_r;
          dv_neg_p_r[i] <= neg_p_r;
          dv_neg_m_r[i] <= neg_m_r;
        end else begin
          dv_code_r[i]  <= dv_code_r[i-1];
          dv_neg_p_r[i] <= dv_neg_p_r[i-1];
          dv_neg_m_r[i] <= dv_neg_m_r[i-1];
        end
      end
    end
  end

  // Sign, saturate, zero when there is no root.
  logic signed [SW-1:0] qs_p, qs_m, sat_p, sat_m, rmax, rmin;
  logic                 no_root;
  qrs_pkg::case_code_t  fin_code;

  always_comb begin
    fin_code = dv_code_r[NS-1];
    rmax     = $signed(SW'({(RTW-1){1'b1}}));
    rmin     = -rmax - 1;
    qs_p     = dv_neg_p_r[NS-1] ? -$signed(SW'(quo_p)) : $signed(SW'(quo_p));
    qs_m     = dv_neg_m_r[NS-1] ? -$signed(SW'(quo_m)) : $signed(SW'(quo_m));
    sat_p    = (qs_p > rmax) ? rmax : ((qs_p < rmin) ? rmin : qs_p);
    sat_m    = (qs_m > rmax) ? rmax : ((qs_m < rmin) ? rmin : qs_m);
    no_root  = (fin_code == qrs_pkg::CASE_NONE) || (fin_code == qrs_pkg::CASE_DEGEN);
  end

  always_ff @(posedge clk) begin
    if (adv) begin
      out_case_code  <= fin_code;
      out_root_plus  <= no_root ? '0 : sat_p[RTW-1:0];
      out_root_minus <= no_root ? '0 : sat_m[RTW-1:0];
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/quadratic_root_solver_core.sv -----
// Top level of the quadratic root solver: front end, queue, back end.
`timescale 1ns / 1ps
`default_nettype none
// Solves a*x^2 + b*x + c = 0 for one coefficient set per beat. The discriminant
// b*b - 4ac is formed exactly; out_case_code reports two roots, a repeated root,
// no real root, the linear root -c/b (a is zero) or the degenerate case (a and b
// zero). Roots are signed fixed point with FRAC_BITS fraction bits (Q20.16 at the
// defaults); the square root is the floor root and divisions truncate toward zero.
// Fields without a root read as zero. The block takes one beat every cycle while
// in_stall is low. Each beat passes a front register, a four-entry queue, one
// discriminant stage, a square-root pipeline retiring two radicand bits per
// stage, one numerator stage, a restoring divider pipeline retiring one quotient
// bit per stage and an output register. A stall on the output holds the back
// end; the queue lets the front keep taking beats meanwhile, until it fills.
module quadratic_root_solver_core #(
  parameter int COEF_WIDTH = qrs_pkg::COEF_WIDTH_DEF,
  parameter int FRAC_BITS  = qrs_pkg::FRAC_BITS_DEF
) (
  input  wire                                   clk,
  input  wire                                   rst_n,
  input  wire                                   in_valid,
  output logic                                  in_stall,
  input  wire  signed [COEF_WIDTH-1:0]          in_coef_a,
  input  wire  signed [COEF_WIDTH-1:0]          in_coef_b,
  input  wire  signed [COEF_WIDTH-1:0]          in_coef_c,
  output logic                                  out_valid,
  input  wire                                   out_stall,
  output logic [2:0]                            out_case_code,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_plus,
  output logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_minus
);

  localparam int CW = COEF_WIDTH;
  localparam int QW = 3 * CW + 4 * CW + $bits(qrs_pkg::qrs_cls_t);

  logic                 fr_valid, q_full, q_empty, q_pop;
  logic signed [CW-1:0] fr_a, fr_b, fr_c, q_a, q_b, q_c;
  logic [2*CW-1:0]      fr_bb, fr_ac, q_bb, q_ac;
  qrs_pkg::qrs_cls_t    fr_cls, q_cls;
  logic [QW-1:0]        q_din, q_dout;

  // Classify and form the products.
  qrs_front #(.COEF_WIDTH(COEF_WIDTH)) u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (in_valid),
    .in_stall  (in_stall),
    .in_coef_a (in_coef_a),
    .in_coef_b (in_coef_b),
    .in_coef_c (in_coef_c),
    .q_full    (q_full),
    .fr_valid  (fr_valid),
    .fr_a      (fr_a),
    .fr_b      (fr_b),
    .fr_c      (fr_c),
    .fr_bb     (fr_bb),
    .fr_ac     (fr_ac),
    .fr_cls    (fr_cls)
  );

  // Decouple front from back.
  assign q_din = {fr_a, fr_b, fr_c, fr_bb, fr_ac, fr_cls};
  assign {q_a, q_b, q_c, q_bb, q_ac, q_cls} = q_dout;

  qrs_fifo #(.WIDTH(QW)) u_fifo (
    .clk   (clk),
    .rst_n (rst_n),
    .push  (fr_valid),
    .din   (q_din),
    .full  (q_full),
    .pop   (q_pop),
    .empty (q_empty),
    .dout  (q_dout)
  );

  // Square root, division and output register.
  qrs_back #(.COEF_WIDTH(COEF_WIDTH), .FRAC_BITS(FRAC_BITS)) u_back (
    .clk            (clk),
    .rst_n          (rst_n),
    .q_empty        (q_empty),
    .q_pop          (q_pop),
    .q_a            (q_a),
    .q_b            (q_b),
    .q_c            (q_c),
    .q_bb           (q_bb),
    .q_ac           (q_ac),
    .q_cls          (q_cls),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_case_code  (out_case_code),
    .out_root_plus  (out_root_plus),
    .out_root_minus (out_root_minus)
  );

endmodule
`default_nettype wire

// ----- tb/quadratic_root_solver_core_tb.sv -----
// Testbench for the quadratic root solver core: random and directed coefficient sets.
`timescale 1ns / 1ps
`default_nettype none

// Holds the roots predicted for each accepted coefficient set and checks results.
class root_board;
  typedef struct {
    logic [2:0]  code;
    logic [36:0] rp;
    logic [36:0] rm;
  } root_set_t;

  root_set_t pending_roots[$];
  int        errors;

  function automatic longint isqrt(logic [127:0] v);
    logic [63:0]  r;
    logic [63:0]  cand;
    logic [127:0] sq;
    r = 0;
    for (int i = 63; i >= 0; i--) begin
      cand = r | (64'd1 << i);
      sq   = {64'd0, cand} * {64'd0, cand};
      if (sq <= v) r = cand;
    end
    return longint'(r);
  endfunction

  function automatic logic [36:0] clamp_root(longint v);
    longint top;
    top = (longint'(1) <<< 36) - 1;
    if (v > top) v = top;
    if (v < -top - 1) v = -top - 1;
    return v[36:0];
  endfunction

  // Work out the expected case and roots for one coefficient set.
  function void note_coefs(logic signed [15:0] ca, logic signed [15:0] cb,
                           logic signed [15:0] cc);
    longint    a;
    longint    b;
    longint    c;
    longint    d;
    longint    nb;
    longint    s;
    longint    rp;
    longint    rm;
    root_set_t e;
    a  = ca;
    b  = cb;
    c  = cc;
    rp = 0;
    rm = 0;
    if (a == 0) begin
      if (b == 0) begin
        e.code = qrs_pkg::CASE_DEGEN;
      end else begin
        e.code = qrs_pkg::CASE_LINEAR;
        rp     = (-c * 65536) / b;
        rm     = rp;
      end
    end else begin
      // |d| stays under 2^34, so it fits a longint exactly
      d  = b * b - 4 * a * c;
      nb = -b * 65536;
      if (d > 0) begin
        e.code = qrs_pkg::CASE_TWO;
        s      = isqrt({64'd0, d} << 32);
        rp     = (nb + s) / (2 * a);
        rm     = (nb - s) / (2 * a);
      end else if (d == 0) begin
        e.code = qrs_pkg::CASE_ONE;
        rp     = nb / (2 * a);
        rm     = rp;
      end else begin
        e.code = qrs_pkg::CASE_NONE;
      end
    end
    e.rp = clamp_root(rp);
    e.rm = clamp_root(rm);
    pending_roots.push_back(e);
  endfunction

  task report_mismatch(string what);
    $display("mismatch: %s", what);
    errors++;
  endtask

  // Compare one result beat with the oldest prediction.
  task check_roots(logic [2:0] code, logic [36:0] rp, logic [36:0] rm);
    root_set_t e;
    if (pending_roots.size() == 0) begin
      report_mismatch("result beat with no coefficient set pending");
      return;
    end
    e = pending_roots.pop_front();
    if (code !== e.code)
      report_mismatch($sformatf("case code %0d, expected %0d", code, e.code));
    if (rp !== e.rp)
      report_mismatch($sformatf("root_plus %h, expected %h", rp, e.rp));
    if (rm !== e.rm)
      report_mismatch($sformatf("root_minus %h, expected %h", rm, e.rm));
  endtask
endclass

module quadratic_root_solver_core_tb;

  logic                                  clk;
  logic                                  rst_n;
  logic                                  in_valid;
  logic                                  in_stall;
  logic signed [15:0]                    in_coef_a;
  logic signed [15:0]                    in_coef_b;
  logic signed [15:0]                    in_coef_c;
  logic                                  out_valid;
  logic                                  out_stall;
  logic [2:0]                            out_case_code;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_plus;
  logic signed [qrs_pkg::ROOT_WIDTH-1:0] out_root_minus;

  root_board board;
  int        send_idle_pct;   // chance in a hundred that the sender idles
  int        stall_pct;       // chance in a hundred that the receiver stalls
  int        hold_cycles;     // long receiver hold-off, counted down below

  quadratic_root_solver_core dut (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .in_coef_a      (in_coef_a),
    .in_coef_b      (in_coef_b),
    .in_coef_c      (in_coef_c),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .out_case_code  (out_case_code),
    .out_root_plus  (out_root_plus),
    .out_root_minus (out_root_minus)
  );

  always begin
    clk = 1'b1;
    #10;
    clk = 1'b0;
    #10;
  end

  // Receiver: stall at random, or hold off completely while hold_cycles runs.
  always @(negedge clk) begin
    if (hold_cycles > 0) begin
      out_stall   <= 1'b1;
      hold_cycles <= hold_cycles - 1;
    end else begin
      out_stall <= ($urandom_range(99) < stall_pct);
    end
  end

  // Sample the result channel on the rising edge and check each accepted beat.
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall)
      board.check_roots(out_case_code, out_root_plus, out_root_minus);
  end

  // Offer one coefficient set, idling at random first; return once it is accepted.
  task automatic send_coefs(logic signed [15:0] a, logic signed [15:0] b,
                            logic signed [15:0] c);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(negedge clk);
    end
    in_valid  <= 1'b1;
    in_coef_a <= a;
    in_coef_b <= b;
    in_coef_c <= c;
    @(posedge clk);
    while (in_stall) @(posedge clk);
    board.note_coefs(a, b, c);
    // Hold valid high here; the next call idles it or offers a new set, or the drain drops it.
    @(negedge clk);
  endtask

  // Pick a coefficient with bias towards zero, small values and the extremes.
  function automatic logic signed [15:0] pick_coef();
    case ($urandom_range(9))
      0:       return 16'sd0;
      1:       return $urandom_range(1) ? 16'sh7fff : 16'sh8000;
      2, 3:    return 16'($signed($urandom_range(16)) - 8);
      4:       return 16'($signed($urandom_range(512)) - 256);
      default: return 16'($urandom);
    endcase
  endfunction

  // Send a random set; often build perfect squares so the repeated root shows up.
  task automatic send_random();
    logic signed [15:0] a;
    logic signed [15:0] b;
    logic signed [15:0] c;
    logic signed [7:0]  p;
    logic signed [7:0]  q;
    if ($urandom_range(7) == 0) begin
      // (p*x + q)^2 = p^2 x^2 + 2pq x + q^2
      p = 8'($urandom_range(180));
      q = 8'($urandom);
      if (p == 0) p = 1;
      a = 16'(32'(p) * p);
      b = 16'(2 * p * q);
      c = 16'(32'(q) * q);
      if ($urandom_range(1)) begin
        a = -a;
        b = -b;
        c = -c;
      end
    end else begin
      a = pick_coef();
      b = pick_coef();
      c = pick_coef();
    end
    send_coefs(a, b, c);
  endtask

  // Drop valid and wait until every expected result has come.
  task automatic wait_drained();
    in_valid <= 1'b0;
    while (board.pending_roots.size() != 0) @(negedge clk);
  endtask

  initial begin
    board         = new();
    rst_n         = 1'b0;
    in_valid      = 1'b0;
    in_coef_a     = '0;
    in_coef_b     = '0;
    in_coef_c     = '0;
    out_stall     = 1'b0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 0;
    repeat (3) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // Directed: every case, the extremes of each field and sign mixes.
    send_coefs(16'sd1, -16'sd3, 16'sd2);        // two roots
    send_coefs(16'sd1, 16'sd2, 16'sd1);         // repeated root
    send_coefs(-16'sd4, 16'sd4, -16'sd1);       // repeated root, negative a
    send_coefs(16'sd1, 16'sd0, 16'sd1);         // no real root
    send_coefs(16'sd0, 16'sd3, 16'sd7);         // linear
    send_coefs(16'sd0, -16'sd1, 16'sh8000);     // linear, extreme c
    send_coefs(16'sd0, 16'sh8000, 16'sh7fff);   // linear, extreme b
    send_coefs(16'sd0, 16'sd0, 16'sd5);         // degenerate
    send_coefs(16'sd0, 16'sd0, 16'sd0);         // degenerate, all zero
    send_coefs(16'sh8000, 16'sh8000, 16'sh7fff);
    send_coefs(16'sh7fff, 16'sh8000, 16'sh8000);
    send_coefs(16'sh7fff, 16'sh7fff, 16'sh7fff);
    send_coefs(16'sh8000, 16'sh8000, 16'sh8000);
    send_coefs(16'sd1, 16'sh8000, 16'sd0);      // largest root magnitude
    send_coefs(-16'sd1, 16'sh7fff, 16'sd0);
    send_coefs(16'sd1, 16'sd0, 16'sh8000);
    send_coefs(16'sd1, 16'sd0, 16'sh7fff);      // no real root at the extreme
    send_coefs(16'shffff, 16'shffff, 16'shffff);
    send_coefs(16'sh5555, 16'shaaaa, 16'sh5555);
    send_coefs(16'sd3, 16'sd0, 16'sd0);         // repeated root at zero
    wait_drained();

    // Random phases: no idling, sender idle, receiver stalling, both.
    for (int ph = 0; ph < 4; ph++) begin
      send_idle_pct = (ph == 1) ? 64 : (ph == 3) ? 10 : 0;
      stall_pct     = (ph == 2) ? 64 : (ph == 3) ? 10 : 0;
      for (int i = 0; i < 350; i++) send_random();
      wait_drained();
    end

    // Hold the receiver off long enough for the queue and pipeline to fill.
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_cycles   = 300;
    for (int i = 0; i < 180; i++) send_random();
    wait_drained();

    repeat (100) @(negedge clk);
    if (board.errors == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

  initial begin
    #5ms;
    $display("FAIL");
    $finish;
  end
endmodule
`default_nettype wire

// ----- sim.f -----
rtl/core/qrs_pkg.sv
rtl/core/qrs_front.sv
rtl/core/qrs_fifo.sv
rtl/core/qrs_div.sv
rtl/core/qrs_back.sv
rtl/core/quadratic_root_solver_core.sv
tb/quadratic_root_solver_core_tb.sv
